/* rtl/core/fhcf_pkg.sv */
// Shared types, constants and helper functions for the frame header CRC framer.
// Used by every module in rtl/core; depends on nothing else.
package fhcf_pkg;

    localparam int HEADER_BYTES   = 30;
    localparam int TRAILER_BYTES  = 4;
    localparam int FRAME_OVERHEAD = HEADER_BYTES + TRAILER_BYTES;
    localparam int IDX_W          = $clog2(HEADER_BYTES);
    localparam int HDR_W          = 8 * HEADER_BYTES;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;

    localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [23:0] MAX_FRAME_RST = 24'd1048576;

    // Input word kinds; the fourth code is unused and dropped on entry.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

    // Register indexes, at byte address 4*index.
    localparam logic [2:0] REG_VERSION   = 3'd0;
    localparam logic [2:0] REG_VP_WIDTH  = 3'd1;
    localparam logic [2:0] REG_VP_HEIGHT = 3'd2;
    localparam logic [2:0] REG_CV_WIDTH  = 3'd3;
    localparam logic [2:0] REG_CV_HEIGHT = 3'd4;
    localparam logic [2:0] REG_MAX_FRAME = 3'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         frame_flags;
        logic [31:0]        frame_number;
        logic signed [63:0] time_ms;
        logic signed [31:0] scroll_horiz;
        logic signed [31:0] scroll_vert;
        logic [7:0]         cmd_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  protocol_version;
        logic [15:0] viewport_width;
        logic [15:0] viewport_height;
        logic [15:0] canvas_width;
        logic [15:0] canvas_height;
        logic [23:0] max_frame_bytes;
    } cfg_t;

    // One byte of the reflected IEEE CRC-32, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/frame_header_crc_framer.sv */
// Top level of the frame header CRC framer: register file plus framing core.
// Depends on fhcf_pkg, fhcf_regs and fhcf_core.
//
// The block assembles frames from a stream of input words. A header word opens a
// frame and expands into 30 header bytes; a command word passes one byte through;
// a finish word closes the frame with the four CRC-32 trailer bytes, least
// significant byte first. The CRC covers the header and the command bytes.
// Results leave on the m_ channel one byte per word, with a status and an
// end-of-frame flag; error results carry a zero byte and always end a frame.
//
// A result byte passes from acceptance through the input word register and then
// the output register. While the receiver does not stall, a command word is taken
// every cycle; a header word holds the byte sequencer for 30 bytes, a finish word
// for 4. The next word is taken in the same cycle as the last byte of the current
// one moves into the output register. When the receiver stalls, the output
// register holds its word and the sequencer waits; s_ready falls once the held
// input word cannot move on. Reset is synchronous and active low: no frame is open,
// the CRC is all ones and the registers return to their reset values (frame limit
// 1048576 bytes). The user must see that registers are written through the
// APB-style port only while the block is idle; the block does not enforce this.
module frame_header_crc_framer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fhcf_pkg::PADDR_W-1:0] paddr,
    input  logic [fhcf_pkg::PDATA_W-1:0] pwdata,
    output logic [fhcf_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  fhcf_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output fhcf_pkg::out_item_t          m_data
);
    import fhcf_pkg::*;

    cfg_t cfg;

    fhcf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fhcf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Nothing is presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid straight after reset");

    // Every error result ends the frame.
    a_err_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |-> m_data.frame_end)
        else $error("error result without end of frame");

    // Error results carry a zero byte.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |-> m_data.out_byte == 8'd0)
        else $error("error result with a non-zero byte");

    // A stalled output keeps the sequencer from taking new input.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && $past(s_valid && s_ready) && $past(aresetn)
            && $past(s_data.kind) != KIND_UNUSED |-> !s_ready)
        else $error("input taken while a word is held behind a stall");

endmodule

/* rtl/core/fhcf_regs.sv */
// Configuration register file with an APB-style slave port.
// Depends on fhcf_pkg for the register indexes and the cfg_t bundle.
module fhcf_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fhcf_pkg::PADDR_W-1:0] paddr,
    input  logic [fhcf_pkg::PDATA_W-1:0] pwdata,
    output logic [fhcf_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output fhcf_pkg::cfg_t               cfg
);
    import fhcf_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol_version <= '0;
            cfg_reg.viewport_width   <= '0;
            cfg_reg.viewport_height  <= '0;
            cfg_reg.canvas_width     <= '0;
            cfg_reg.canvas_height    <= '0;
            cfg_reg.max_frame_bytes  <= MAX_FRAME_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_VERSION:   cfg_reg.protocol_version <= pwdata[7:0];
                REG_VP_WIDTH:  cfg_reg.viewport_width   <= pwdata[15:0];
                REG_VP_HEIGHT: cfg_reg.viewport_height  <= pwdata[15:0];
                REG_CV_WIDTH:  cfg_reg.canvas_width     <= pwdata[15:0];
                REG_CV_HEIGHT: cfg_reg.canvas_height    <= pwdata[15:0];
                REG_MAX_FRAME: cfg_reg.max_frame_bytes  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VERSION:   prdata = {24'd0, cfg_reg.protocol_version};
            REG_VP_WIDTH:  prdata = {16'd0, cfg_reg.viewport_width};
            REG_VP_HEIGHT: prdata = {16'd0, cfg_reg.viewport_height};
            REG_CV_WIDTH:  prdata = {16'd0, cfg_reg.canvas_width};
            REG_CV_HEIGHT: prdata = {16'd0, cfg_reg.canvas_height};
            REG_MAX_FRAME: prdata = {8'd0, cfg_reg.max_frame_bytes};
            default:       prdata = '0;
        endcase
    end

endmodule

/* rtl/core/fhcf_core.sv */
// Word register, byte sequencer, frame state and output register of the framer.
// Depends on fhcf_pkg for the word types, codes and the CRC step.
module fhcf_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  fhcf_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  fhcf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fhcf_pkg::out_item_t m_data
);
    import fhcf_pkg::*;

    in_item_t         item_reg;
    logic             item_valid_reg, item_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             open_reg, open_next;
    logic [31:0]      crc_reg, crc_next;
    logic [23:0]      count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             emit_go;
    logic             last;
    logic             accept;
    logic [HDR_W-1:0] hdr;
    logic [7:0]       hdr_byte;
    logic [31:0]      crc_fin;
    logic             limit_ok;
    logic             cmd_over;

    // Header image, byte 0 in the least significant position.
    assign hdr = {cfg.canvas_height, cfg.canvas_width, cfg.viewport_height,
                  cfg.viewport_width, item_reg.scroll_vert, item_reg.scroll_horiz,
                  item_reg.time_ms, item_reg.frame_number, item_reg.frame_flags,
                  cfg.protocol_version};
    assign hdr_byte = hdr[{idx_reg, 3'b000} +: 8];
    assign crc_fin  = ~crc_reg;
    assign limit_ok = cfg.max_frame_bytes >= 24'(FRAME_OVERHEAD);
    assign cmd_over = ({1'b0, count_reg} + 25'(FRAME_OVERHEAD + 1)) > {1'b0, cfg.max_frame_bytes};

    assign emit_go = item_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || (emit_go && last);
    assign accept  = s_valid && s_ready;

    always_comb begin
        last        = 1'b1;
        open_next   = open_reg;
        crc_next    = crc_reg;
        count_next  = count_reg;
        m_data_next = '{out_byte: 8'd0, status: STATUS_OK, frame_end: 1'b1};
        unique case (item_reg.kind)
            KIND_HEADER: begin
                if (!limit_ok) begin
                    m_data_next.status = STATUS_TOO_LONG;
                    open_next          = 1'b0;
                end else begin
                    last                  = idx_reg == IDX_W'(HEADER_BYTES - 1);
                    m_data_next.out_byte  = hdr_byte;
                    m_data_next.frame_end = 1'b0;
                    crc_next = crc_byte((idx_reg == '0) ? CRC_ONES : crc_reg, hdr_byte);
                    if (last) begin
                        open_next  = 1'b1;
                        count_next = '0;
                    end
                end
            end
            KIND_CMD: begin
                if (!open_reg) begin
                    m_data_next.status = STATUS_NO_FRAME;
                end else if (cmd_over) begin
                    m_data_next.status = STATUS_TOO_LONG;
                    open_next          = 1'b0;
                end else begin
                    m_data_next.out_byte  = item_reg.cmd_byte;
                    m_data_next.frame_end = 1'b0;
                    crc_next   = crc_byte(crc_reg, item_reg.cmd_byte);
                    count_next = count_reg + 24'd1;
                end
            end
            KIND_FINISH: begin
                if (!open_reg) begin
                    m_data_next.status = STATUS_NO_FRAME;
                end else begin
                    last                  = idx_reg == IDX_W'(TRAILER_BYTES - 1);
                    m_data_next.out_byte  = crc_fin[{idx_reg[1:0], 3'b000} +: 8];
                    m_data_next.frame_end = last;
                    if (last) begin
                        open_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        item_valid_next = item_valid_reg;
        idx_next        = idx_reg;
        if (accept) begin
            // The unused kind code produces nothing, so it is never held.
            item_valid_next = s_data.kind != KIND_UNUSED;
            idx_next        = '0;
        end else if (emit_go && last) begin
            item_valid_next = 1'b0;
        end else if (emit_go) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        m_valid_next = m_valid_reg;
        if (emit_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            open_reg       <= 1'b0;
            crc_reg        <= CRC_ONES;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
            if (emit_go) begin
                open_reg  <= open_next;
                crc_reg   <= crc_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (emit_go) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sim/tb.sv */
// Self-checking testbench for frame_header_crc_framer: it drives header, command and finish
// words, predicts every result byte including the CRC-32 trailer, and checks each one.
// Depends on fhcf_pkg and the RTL under rtl/core only; it reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhcf_pkg::*;

    // Watchdog bound; the slowest legal run has every word expanding to 30 bytes and
    // each byte waiting out the longest receiver stall, and must finish within it.
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int QUIET_LIMIT   = 20_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 40;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;

    // Shadow of the register file and of the framing state, kept in step with the block.
    cfg_t        cfg_shadow;
    logic        frame_live;
    logic [31:0] crc_acc;
    logic [23:0] cmd_count;

    // Result bytes still owed by the block, oldest first.
    out_item_t   expected_bytes[$];

    int mismatches      = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int cycles          = 0;

    // Random idling on both sides is switched off for stretches by clearing this flag.
    bit idle_en = 1'b1;
    // Cycles for which the receiver must hold off regardless of anything else.
    int sink_hold = 0;

    frame_header_crc_framer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("frame_header_crc_framer verification failed");
            $finish;
        end
    end

    task automatic log_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
        mismatches++;
    endtask

    // Reflected CRC-32, one byte at a time; the polynomial is applied through a mask
    // built from the bit that falls out.
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        return r;
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input logic [1:0] st,
                                        input logic last);
        out_item_t e;
        e.out_byte  = b;
        e.status    = st;
        e.frame_end = last;
        expected_bytes.insert(expected_bytes.size(), e);
    endfunction

    // Works out the result bytes that one accepted word causes and advances the shadow
    // framing state exactly as the block should.
    function automatic void predict_frame_bytes(input in_item_t w);
        logic [7:0]  hdr [HEADER_BYTES];
        logic [31:0] crc;
        logic [31:0] trailer;
        int          i;
        case (w.kind)
            KIND_HEADER: begin
                // Any frame still open is abandoned without a trace.
                frame_live = 1'b0;
                if (FRAME_OVERHEAD > int'(cfg_shadow.max_frame_bytes)) begin
                    // Not even an empty frame fits under the limit.
                    expect_byte(8'h00, STATUS_TOO_LONG, 1'b1);
                end else begin
                    hdr[0] = cfg_shadow.protocol_version;
                    hdr[1] = w.frame_flags;
                    for (i = 0; i < 4; i++) begin
                        hdr[2 + i]  = w.frame_number[8*i +: 8];
                        hdr[14 + i] = w.scroll_horiz[8*i +: 8];
                        hdr[18 + i] = w.scroll_vert[8*i +: 8];
                    end
                    for (i = 0; i < 8; i++) begin
                        hdr[6 + i] = w.time_ms[8*i +: 8];
                    end
                    for (i = 0; i < 2; i++) begin
                        hdr[22 + i] = cfg_shadow.viewport_width[8*i +: 8];
                        hdr[24 + i] = cfg_shadow.viewport_height[8*i +: 8];
                        hdr[26 + i] = cfg_shadow.canvas_width[8*i +: 8];
                        hdr[28 + i] = cfg_shadow.canvas_height[8*i +: 8];
                    end
                    crc = CRC_ONES;
                    for (i = 0; i < HEADER_BYTES; i++) begin
                        crc = crc32_update(crc, hdr[i]);
                        expect_byte(hdr[i], STATUS_OK, 1'b0);
                    end
                    crc_acc    = crc;
                    cmd_count  = '0;
                    frame_live = 1'b1;
                end
            end
            KIND_CMD: begin
                if (!frame_live) begin
                    expect_byte(8'h00, STATUS_NO_FRAME, 1'b1);
                end else if (FRAME_OVERHEAD + int'(cmd_count) + 1 >
                             int'(cfg_shadow.max_frame_bytes)) begin
                    // The overflowing byte is dropped and the frame is closed.
                    frame_live = 1'b0;
                    expect_byte(8'h00, STATUS_TOO_LONG, 1'b1);
                end else begin
                    crc_acc   = crc32_update(crc_acc, w.cmd_byte);
                    cmd_count = cmd_count + 24'd1;
                    expect_byte(w.cmd_byte, STATUS_OK, 1'b0);
                end
            end
            KIND_FINISH: begin
                if (!frame_live) begin
                    expect_byte(8'h00, STATUS_NO_FRAME, 1'b1);
                end else begin
                    trailer = crc_acc ^ CRC_ONES;
                    for (i = 0; i < TRAILER_BYTES; i++) begin
                        expect_byte(trailer[8*i +: 8], STATUS_OK, i == TRAILER_BYTES - 1);
                    end
                    frame_live = 1'b0;
                end
            end
            default: begin
                // The unused kind leaves the block untouched.
            end
        endcase
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t rand_word(input logic [1:0] k);
        in_item_t w;
        w.kind         = k;
        w.frame_flags  = 8'($urandom);
        w.frame_number = $urandom;
        w.time_ms      = {$urandom, $urandom};
        w.scroll_horiz = $urandom;
        w.scroll_vert  = $urandom;
        w.cmd_byte     = 8'($urandom);
        return w;
    endfunction

    function automatic cfg_t rand_config(input bit tight_limit);
        cfg_t c;
        int   r;
        c.protocol_version = 8'($urandom);
        c.viewport_width   = 16'($urandom);
        c.viewport_height  = 16'($urandom);
        c.canvas_width     = 16'($urandom);
        c.canvas_height    = 16'($urandom);
        r = $urandom_range(0, 99);
        if (tight_limit || r < 30) begin
            c.max_frame_bytes = 24'($urandom_range(FRAME_OVERHEAD, 80));
        end else if (r < 36) begin
            c.max_frame_bytes = 24'($urandom_range(30, FRAME_OVERHEAD - 1));
        end else if (r < 46) begin
            c.max_frame_bytes = 24'hFF_FFFF;
        end else begin
            c.max_frame_bytes = 24'($urandom_range(81, 24'hFF_FFFF));
        end
        return c;
    endfunction

    // Offers one word after an optional gap and waits for the handshake. Valid is only
    // lowered at the start of a gap, so back-to-back words keep it high throughout.
    task automatic send_word(input in_item_t w);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_frame_bytes(w);
        if (w.kind != KIND_UNUSED) begin
            words_sent++;
        end
    endtask

    // One APB write: setup cycle, then access cycle. The bus stays selected between
    // back-to-back writes and is parked by the caller.
    task automatic reg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic load_config(input cfg_t c);
        reg_write(REG_VERSION,   {24'd0, c.protocol_version});
        reg_write(REG_VP_WIDTH,  {16'd0, c.viewport_width});
        reg_write(REG_VP_HEIGHT, {16'd0, c.viewport_height});
        reg_write(REG_CV_WIDTH,  {16'd0, c.canvas_width});
        reg_write(REG_CV_HEIGHT, {16'd0, c.canvas_height});
        reg_write(REG_MAX_FRAME, {8'd0, c.max_frame_bytes});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_shadow = c;
    endtask

    // Stops offering words and waits until every owed byte has arrived, then lets the
    // pipeline settle in case the last word was one that causes no result.
    task automatic wait_quiet();
        int n;
        s_valid <= 1'b0;
        n = 0;
        while (expected_bytes.size() != 0 && n < QUIET_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        if (expected_bytes.size() != 0) begin
            log_mismatch($sformatf("%0d expected result bytes never arrived",
                                   expected_bytes.size()));
            expected_bytes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver pacing. A requested hold-off is counted down here and overrides the
    // random stalls; with idling switched off the receiver is always ready.
    initial begin : sink_pacing
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_ready   <= 1'b0;
                sink_hold = sink_hold - 1;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall   = stall - 1;
            end else begin
                m_ready <= 1'b1;
                if (idle_en && $urandom_range(0, 3) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    // Every accepted result word is compared with the oldest owed byte.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                log_mismatch($sformatf("result %0d unexpected: byte %02h status %0d end %0b",
                                       results_checked, m_data.out_byte, m_data.status,
                                       m_data.frame_end));
            end else begin
                want = expected_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    log_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                           results_checked, m_data.out_byte, want.out_byte));
                end
                if (m_data.status !== want.status) begin
                    log_mismatch($sformatf("result %0d status %0d, expected %0d",
                                           results_checked, m_data.status, want.status));
                end
                if (m_data.frame_end !== want.frame_end) begin
                    log_mismatch($sformatf("result %0d frame_end %0b, expected %0b",
                                           results_checked, m_data.frame_end,
                                           want.frame_end));
                end
            end
            results_checked++;
        end
    end

    // Reset register values, all-zero and all-ones headers, the extreme command bytes,
    // an ignored word inside a frame and a header that replaces an open frame.
    task automatic test_basic_frames();
        in_item_t w;
        w = '0;
        w.kind = KIND_HEADER;
        send_word(w);
        w = rand_word(KIND_CMD);
        w.cmd_byte = 8'h00;
        send_word(w);
        send_word(rand_word(KIND_UNUSED));
        w.cmd_byte = 8'hFF;
        send_word(w);
        send_word(rand_word(KIND_FINISH));
        w = '1;
        w.kind = KIND_HEADER;
        send_word(w);
        // Most negative timestamp and scroll offsets, sent while the previous frame is open.
        w = '0;
        w.kind         = KIND_HEADER;
        w.time_ms      = {1'b1, 63'd0};
        w.scroll_horiz = {1'b1, 31'd0};
        w.scroll_vert  = {1'b1, 31'd0};
        send_word(w);
        send_word(rand_word(KIND_CMD));
        send_word(rand_word(KIND_FINISH));
    endtask

    // Command and finish words with no frame open must be refused.
    task automatic test_no_open_frame();
        send_word(rand_word(KIND_CMD));
        send_word(rand_word(KIND_FINISH));
    endtask

    // Registers at their extremes, then the frame limit at, below and just above the
    // size of an empty frame.
    task automatic test_register_extremes();
        cfg_t     c;
        in_item_t w;
        wait_quiet();
        c = '1;
        load_config(c);
        w = '0;
        w.kind         = KIND_HEADER;
        w.time_ms      = {1'b0, {63{1'b1}}};
        w.scroll_horiz = {1'b0, {31{1'b1}}};
        w.scroll_vert  = {1'b0, {31{1'b1}}};
        send_word(w);
        send_word(rand_word(KIND_CMD));
        send_word(rand_word(KIND_FINISH));

        // Room for the header and trailer only: the first command word overflows.
        wait_quiet();
        c.max_frame_bytes = 24'(FRAME_OVERHEAD);
        load_config(c);
        send_word(rand_word(KIND_HEADER));
        send_word(rand_word(KIND_CMD));
        send_word(rand_word(KIND_CMD));
        send_word(rand_word(KIND_HEADER));
        send_word(rand_word(KIND_FINISH));

        // Limit below an empty frame: the header itself is refused and nothing opens.
        wait_quiet();
        c.max_frame_bytes = 24'(FRAME_OVERHEAD - 1);
        load_config(c);
        send_word(rand_word(KIND_HEADER));
        send_word(rand_word(KIND_FINISH));

        // Zeroed header registers and room for exactly two command bytes.
        wait_quiet();
        c = '0;
        c.max_frame_bytes = 24'(FRAME_OVERHEAD + 2);
        load_config(c);
        send_word(rand_word(KIND_HEADER));
        send_word(rand_word(KIND_CMD));
        send_word(rand_word(KIND_CMD));
        send_word(rand_word(KIND_CMD));
    endtask

    // Mostly complete frames with random content and length, over several register
    // settings; the rest are truncated frames, stray words and ignored words.
    task automatic test_random_frames(input int target);
        int phase_end;
        int p;
        int r;
        int len_pick;
        int n;
        for (p = 0; p < 5; p++) begin
            wait_quiet();
            // The second setting always has a tight limit so that overflow is exercised.
            load_config(rand_config(p == 1));
            phase_end = words_sent + target / 5;
            while (words_sent < phase_end) begin
                idle_en = ($urandom_range(0, 4) != 0);
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_word(rand_word(KIND_HEADER));
                    len_pick = $urandom_range(0, 99);
                    n = (len_pick < 70) ? $urandom_range(0, 8) :
                        (len_pick < 95) ? $urandom_range(9, 30) : $urandom_range(31, 60);
                    repeat (n) send_word(rand_word(KIND_CMD));
                    // A few frames are left open, to be continued, closed or replaced by whatever word comes next.
                    if (r < 72) begin
                        send_word(rand_word(KIND_FINISH));
                    end
                end else if (r < 92) begin
                    send_word(rand_word($urandom_range(0, 1) ? KIND_CMD : KIND_FINISH));
                end else begin
                    send_word(rand_word(KIND_UNUSED));
                end
            end
        end
        idle_en = 1'b1;
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the block
    // fills up and has to stall its input.
    task automatic test_output_backpressure();
        cfg_t c;
        int   i;
        wait_quiet();
        c = rand_config(1'b0);
        c.max_frame_bytes = 24'hFF_FFFF;
        load_config(c);
        idle_en   = 1'b0;
        sink_hold = 400;
        for (i = 0; i < 8; i++) begin
            send_word(rand_word(KIND_HEADER));
            send_word(rand_word(KIND_CMD));
            send_word(rand_word(KIND_FINISH));
        end
        idle_en = 1'b1;
    endtask

    initial begin
        // Shadow state matches the block's reset values.
        cfg_shadow = '0;
        cfg_shadow.max_frame_bytes = MAX_FRAME_RST;
        frame_live = 1'b0;
        crc_acc    = CRC_ONES;
        cmd_count  = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_frames();
        test_no_open_frame();
        test_register_extremes();
        test_random_frames(260);
        test_output_backpressure();
        wait_quiet();

        if (mismatches == 0) begin
            $display("frame_header_crc_framer verification clean");
        end else begin
            $display("frame_header_crc_framer verification failed");
        end
        $finish;
    end

endmodule
